// File: rtl/rtch_pkg.sv
`default_nettype none
package rtch_pkg;
  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS = 10;
  localparam int BARY_BITS = 17;
  localparam int TEX_BITS = 16;
  localparam int NORM_BITS = 48;
  localparam int MAT_BITS = 8;
  localparam int EPS_BITS = 16;
  localparam int CFG_ADDR_BITS = 6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN = 6'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIR = 6'd8;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN = 6'd16;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX = 6'd24;
  localparam logic [CFG_ADDR_BITS-1:0] REG_EPS = 6'd32;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd107;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_COMMIT,
    ST_OUT
  } rtch_state_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
    logic open_query;
    logic emit;
  } rtch_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } rtch_sts_t;
endpackage
`default_nettype wire

// File: rtl/rtch_ctrl.sv
`default_nettype none
module rtch_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_fire,
  input  wire rtch_pkg::rtch_sts_t sts,
  output rtch_pkg::rtch_cmd_t    cmd,
  output logic                   in_rdy,
  output logic                   out_vld
);
  import rtch_pkg::*;
  rtch_state_t state_r, state_nxt;
  logic open_r, open_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      open_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r <= open_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt = open_r;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.open_query = !open_r;
          open_nxt = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.start_div = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.last) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_vld = 1'b1;
        cmd.emit = 1'b1;
        if (out_fire) begin
          open_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_vld |-> !in_rdy)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> state_r == ST_SETUP)
    else $error("item not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_fire) |=> !open_r)
    else $error("query not closed");
endmodule
`default_nettype wire

// File: rtl/rtch_dp.sv
`default_nettype none
module rtch_dp #(
  parameter int COORD_BITS = rtch_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire rtch_pkg::rtch_cmd_t     cmd,
  output rtch_pkg::rtch_sts_t          sts,
  input  wire logic [3*COORD_BITS-1:0] origin,
  input  wire logic [3*COORD_BITS-1:0] dir,
  input  wire logic signed [COORD_BITS-1:0] min_d,
  input  wire logic signed [COORD_BITS-1:0] max_d,
  input  wire logic [15:0]             eps,
  input  wire logic [3*COORD_BITS-1:0] v0,
  input  wire logic [3*COORD_BITS-1:0] v1,
  input  wire logic [3*COORD_BITS-1:0] v2,
  input  wire logic [47:0]             nrm,
  input  wire logic [31:0]             tc0,
  input  wire logic [31:0]             tc1,
  input  wire logic [31:0]             tc2,
  input  wire logic [7:0]              mat,
  input  wire logic                    last,
  output logic                         o_hit,
  output logic signed [COORD_BITS-1:0] o_dist,
  output logic [16:0]                  o_u,
  output logic [16:0]                  o_v,
  output logic [3*COORD_BITS-1:0]      o_point,
  output logic [47:0]                  o_nrm,
  output logic [7:0]                   o_mat,
  output logic [31:0]                  o_tex
);
  import rtch_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int EB = CB + 1;
  localparam int CW = 2 * EB + 2;
  localparam int DW = 3 * CW + 4;
  localparam int NW = DW + 17;
  localparam int QB = CB + 2;
  localparam int CNTW = $clog2(NW + 1);

  logic [47:0] nrm_r;
  logic [31:0] tc0_r, tc1_r, tc2_r;
  logic [7:0] mat_r;
  logic last_r;

  logic signed [EB-1:0] ea[3], eb[3], of[3], dv[3];
  logic signed [CW-1:0] pv[3], qv[3];
  logic signed [EB-1:0] ea_r[3], eb_r[3], of_r[3], dv_r[3];
  logic signed [CW-1:0] pv_r[3], qv_r[3];
  logic signed [DW-1:0] det_c, un_c, vn_c, tn_c;
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r;
  logic ok_r;

  // edges and cross products from the incoming item
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ea[k] = EB'($signed(v1[k*CB +: CB])) - EB'($signed(v0[k*CB +: CB]));
      eb[k] = EB'($signed(v2[k*CB +: CB])) - EB'($signed(v0[k*CB +: CB]));
      of[k] = EB'($signed(origin[k*CB +: CB])) - EB'($signed(v0[k*CB +: CB]));
      dv[k] = EB'($signed(dir[k*CB +: CB]));
    end
    pv[0] = CW'(dv[1] * eb[2]) - CW'(dv[2] * eb[1]);
    pv[1] = CW'(dv[2] * eb[0]) - CW'(dv[0] * eb[2]);
    pv[2] = CW'(dv[0] * eb[1]) - CW'(dv[1] * eb[0]);
    qv[0] = CW'(of[1] * ea[2]) - CW'(of[2] * ea[1]);
    qv[1] = CW'(of[2] * ea[0]) - CW'(of[0] * ea[2]);
    qv[2] = CW'(of[0] * ea[1]) - CW'(of[1] * ea[0]);
  end

  // dot products from the registered cross products
  always_comb begin
    det_c = DW'(ea_r[0] * pv_r[0]) + DW'(ea_r[1] * pv_r[1]) + DW'(ea_r[2] * pv_r[2]);
    un_c = DW'(of_r[0] * pv_r[0]) + DW'(of_r[1] * pv_r[1]) + DW'(of_r[2] * pv_r[2]);
    vn_c = DW'(dv_r[0] * qv_r[0]) + DW'(dv_r[1] * qv_r[1]) + DW'(dv_r[2] * qv_r[2]);
    tn_c = DW'(eb_r[0] * qv_r[0]) + DW'(eb_r[1] * qv_r[1]) + DW'(eb_r[2] * qv_r[2]);
    if (det_c < 0) begin
      det_c = -det_c;
      un_c = -un_c;
      vn_c = -vn_c;
      tn_c = -tn_c;
    end
  end

  // three shared-timing restoring dividers, one quotient bit per cycle
  logic [NW-1:0] tnum_r, unum_r, vnum_r;
  logic [NW:0] trem_r, urem_r, vrem_r;
  logic [NW-1:0] tq_r, uq_r, vq_r;
  logic [CNTW-1:0] cnt_r;
  logic tneg_r;
  logic [NW:0] trs, urs, vrs;
  logic [NW:0] den_x;

  assign den_x = (NW+1)'($unsigned(det_r));
  assign trs = {trem_r[NW-1:0], tnum_r[NW-1]};
  assign urs = {urem_r[NW-1:0], unum_r[NW-1]};
  assign vrs = {vrem_r[NW-1:0], vnum_r[NW-1]};
  assign sts.div_done = (cnt_r == '0);
  assign sts.last = last_r;

  logic [DW-1:0] tmag;
  assign tmag = tn_r[DW-1] ? DW'(-tn_r) : DW'(tn_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ea_r <= ea; eb_r <= eb; of_r <= of; dv_r <= dv; pv_r <= pv; qv_r <= qv;
      nrm_r <= nrm;
      tc0_r <= tc0; tc1_r <= tc1; tc2_r <= tc2; mat_r <= mat; last_r <= last;
    end
    if (cmd.start_div) begin
      det_r <= det_c; un_r <= un_c; vn_r <= vn_c; tn_r <= tn_c;
      ok_r <= !(det_c < DW'(eps)) && det_c != '0 && !(un_c < 0) && !(det_c < un_c)
              && !(vn_c < 0) && !(det_c < un_c + vn_c);
      cnt_r <= CNTW'(NW + 1);
    end else if (cnt_r == CNTW'(NW + 1)) begin
      tnum_r <= NW'(tmag) << FRAC_BITS;
      unum_r <= NW'($unsigned(un_r)) << 16;
      vnum_r <= NW'($unsigned(vn_r)) << 16;
      tneg_r <= tn_r[DW-1];
      trem_r <= '0; urem_r <= '0; vrem_r <= '0;
      tq_r <= '0; uq_r <= '0; vq_r <= '0;
      cnt_r <= cnt_r - 1'b1;
    end else if (cnt_r != '0) begin
      tnum_r <= tnum_r << 1; unum_r <= unum_r << 1; vnum_r <= vnum_r << 1;
      trem_r <= (trs >= den_x) ? trs - den_x : trs;
      urem_r <= (urs >= den_x) ? urs - den_x : urs;
      vrem_r <= (vrs >= den_x) ? vrs - den_x : vrs;
      tq_r <= {tq_r[NW-2:0], trs >= den_x};
      uq_r <= {uq_r[NW-2:0], urs >= den_x};
      vq_r <= {vq_r[NW-2:0], vrs >= den_x};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // commit stage
  logic [QB-1:0] tmq;
  logic signed [QB-1:0] tval;
  logic [16:0] uq, vq, wq;
  logic signed [CB+EB+2:0] prod[3];
  logic signed [CB+EB+2:0] pt[3];
  logic [3*CB-1:0] pt_pack;
  logic signed [40:0] ts[2];
  logic [31:0] tex_pack;
  logic acc;
  logic signed [CB-1:0] best_d_r;
  logic hit_r;
  logic [16:0] bu_r, bv_r;
  logic [3*CB-1:0] bp_r;
  logic [47:0] bn_r;
  logic [7:0] bm_r;
  logic [31:0] bt_r;

  always_comb begin
    tmq = (tq_r > NW'(1 << CB)) ? QB'(1 << CB) : QB'(tq_r);
    tval = tneg_r ? -$signed(tmq) : $signed(tmq);
    uq = 17'(uq_r);
    vq = 17'(vq_r);
    wq = 17'd65536 - uq - vq;
    acc = ok_r && !(tval < QB'(min_d)) && !(tval > QB'(best_d_r));
    for (int k = 0; k < 3; k++) begin
      prod[k] = (CB+EB+3)'($signed(dir[k*CB +: CB])) * (CB+EB+3)'(tval);
      pt[k] = (CB+EB+3)'($signed(origin[k*CB +: CB])) + prod[k] / 1024;
      if (pt[k] > (CB+EB+3)'((1 << (CB-1)) - 1)) begin
        pt_pack[k*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
      end else if (pt[k] < -(CB+EB+3)'(1 << (CB-1))) begin
        pt_pack[k*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        pt_pack[k*CB +: CB] = pt[k][CB-1:0];
      end
    end
    for (int j = 0; j < 2; j++) begin
      ts[j] = (41'($signed({1'b0, wq})) * 41'($signed(tc0_r[j*16 +: 16]))
             + 41'($signed({1'b0, uq})) * 41'($signed(tc1_r[j*16 +: 16]))
             + 41'($signed({1'b0, vq})) * 41'($signed(tc2_r[j*16 +: 16]))) / 65536;
      if (ts[j] > 41'sd32767) tex_pack[j*16 +: 16] = 16'h7fff;
      else if (ts[j] < -41'sd32768) tex_pack[j*16 +: 16] = 16'h8000;
      else tex_pack[j*16 +: 16] = ts[j][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open_query) begin
      hit_r <= 1'b0; best_d_r <= max_d; bu_r <= '0; bv_r <= '0;
      bp_r <= '0; bn_r <= '0; bm_r <= '0; bt_r <= '0;
    end else if (cmd.commit && acc) begin
      hit_r <= 1'b1; best_d_r <= CB'(tval); bu_r <= uq; bv_r <= vq;
      bp_r <= pt_pack; bn_r <= nrm_r; bm_r <= mat_r; bt_r <= tex_pack;
    end
  end

  assign o_hit = hit_r;
  assign o_dist = best_d_r;
  assign o_u = bu_r;
  assign o_v = bv_r;
  assign o_point = bp_r;
  assign o_nrm = bn_r;
  assign o_mat = bm_r;
  assign o_tex = bt_r;

  assert property (@(posedge clk) (cmd.commit && acc) |-> ok_r)
    else $error("commit of rejected triangle");
  assert property (@(posedge clk) cmd.commit |-> cnt_r == '0)
    else $error("commit before division end");
  assert property (@(posedge clk) (cmd.commit && acc) |-> uq + vq <= 17'd65536)
    else $error("barycentrics out of range");
endmodule
`default_nettype wire

// File: rtl/ray_triangle_closest_hit.sv
// sequence: a triangle is accepted (load), then setup, divider start, 6*COORD_BITS+33 quotient
// bits, done and commit; the result is offered the cycle after the last triangle commits
// flow: the bit-serial divider holds off the next triangle until the current one has committed;
// a pending result holds off the next triangle until it is taken
// reset: synchronous active low, control and configuration registers to defaults, no query open
`default_nettype none
module ray_triangle_closest_hit #(
  parameter int COORD_BITS = rtch_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // vertex_0, vertex_1, vertex_2, face_normal, tex_coord_0..2, material
  input  wire logic [((9*COORD_BITS+152+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // hit_distance, bary_u, bary_v, point_x, point_y, point_z, hit_normal, hit_material,
  // tex_u, tex_v
  output logic [((4*COORD_BITS+122+7)/8)*8-1:0] out_tdata,
  // hit
  output logic      out_tuser,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [rtch_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic cfg_pready
);
  import rtch_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int OW = ((4*CB+122+7)/8)*8;

  logic [3*CB-1:0] org_r, dir_r;
  logic signed [CB-1:0] min_r, max_r;
  logic [EPS_BITS-1:0] eps_r;
  logic wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0; dir_r <= '0; min_r <= CB'(1);
      max_r <= CB'((1 << (CB-1)) - 1); eps_r <= EPS_RESET;
    end else if (wr) begin
      unique case (cfg_paddr)
        REG_ORIGIN: org_r <= cfg_pwdata[3*CB-1:0];
        REG_DIR: dir_r <= cfg_pwdata[3*CB-1:0];
        REG_MIN: min_r <= cfg_pwdata[CB-1:0];
        REG_MAX: max_r <= cfg_pwdata[CB-1:0];
        REG_EPS: eps_r <= cfg_pwdata[EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_ORIGIN: cfg_prdata = 64'(org_r);
      REG_DIR: cfg_prdata = 64'(dir_r);
      REG_MIN: cfg_prdata = 64'($signed(min_r));
      REG_MAX: cfg_prdata = 64'($signed(max_r));
      REG_EPS: cfg_prdata = 64'(eps_r);
      default: cfg_prdata = '0;
    endcase
  end

  rtch_cmd_t cmd;
  rtch_sts_t sts;
  logic in_fire, out_fire;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  rtch_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .in_rdy(in_tready), .out_vld(out_tvalid)
  );

  logic o_hit;
  logic signed [CB-1:0] o_dist;
  logic [16:0] o_u, o_v;
  logic [3*CB-1:0] o_pt;
  logic [47:0] o_nrm;
  logic [7:0] o_mat;
  logic [31:0] o_tex;

  rtch_dp #(.COORD_BITS(CB)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .origin(org_r), .dir(dir_r),
    .min_d(min_r), .max_d(max_r), .eps(eps_r),
    .v0(in_tdata[0 +: 3*CB]), .v1(in_tdata[3*CB +: 3*CB]), .v2(in_tdata[6*CB +: 3*CB]),
    .nrm(in_tdata[9*CB +: 48]), .tc0(in_tdata[9*CB+48 +: 32]),
    .tc1(in_tdata[9*CB+80 +: 32]), .tc2(in_tdata[9*CB+112 +: 32]),
    .mat(in_tdata[9*CB+144 +: 8]), .last(in_tlast),
    .o_hit(o_hit), .o_dist(o_dist), .o_u(o_u), .o_v(o_v), .o_point(o_pt),
    .o_nrm(o_nrm), .o_mat(o_mat), .o_tex(o_tex)
  );

  assign out_tuser = o_hit;
  assign out_tdata = OW'({o_tex, o_mat, o_nrm, o_pt, o_v, o_u, o_dist});

  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("overlap of item and result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tuser)
    |-> out_tdata[CB-1:0] == max_r)
    else $error("no-hit distance wrong");
endmodule
`default_nettype wire
